// ----- rtl/nmsth_pkg.sv -----
// Shared types and constants for the 3x3 non-maximum suppression core.
`default_nettype none

package nmsth_pkg;

    // Field widths fixed by the stream format
    localparam int SAMPLE_W = 32;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int FW_W     = 12;
    localparam int FH_W     = 13;
    localparam int THR_W    = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // Register reset values and frame limits
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
    localparam logic [THR_W-1:0] THRESHOLD_RST    = 23'd15000;
    localparam logic [FH_W-1:0]  MAX_HEIGHT       = 13'd4096;
    localparam int               MIN_DIM          = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Position and framing of one centre pixel
    typedef struct packed {
        logic              emit;
        logic [COL_W-1:0]  center_column;
        logic [ROW_W-1:0]  center_row;
        logic              frame_end;
    } t_tag;

    // One result item
    typedef struct packed {
        logic              is_corner;
        logic [COL_W-1:0]  center_column;
        logic [ROW_W-1:0]  center_row;
        logic              frame_end;
    } t_result;

    // Results still in the window pipeline, used for output credit
    typedef struct packed {
        logic s1_emit;
        logic s2_emit;
    } t_pipe_stat;

endpackage

`default_nettype wire

// ----- rtl/nmsth_window.sv -----
// Line memory, 3x3 window and local-maximum test.
`default_nettype none

module nmsth_window #(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 8,
    parameter int AW        = 11
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    input  wire  [AW-1:0]               i_addr,
    input  wire  nmsth_pkg::t_sample    i_sample,
    input  wire  nmsth_pkg::t_tag       i_tag,
    input  wire  [nmsth_pkg::THR_W-1:0] i_threshold,
    output logic                        o_res_valid,
    output nmsth_pkg::t_result          o_res,
    output nmsth_pkg::t_pipe_stat       o_stat
);
    import nmsth_pkg::*;

    // Each entry holds {line two above, line one above} for one column
    logic [2*SAMPLE_W-1:0] r_line [MAX_WIDTH];
    logic [2*SAMPLE_W-1:0] r_rd;

    logic            r_s1_valid;
    logic [AW-1:0]   r_s1_addr;
    t_sample         r_s1_sample;
    t_tag            r_s1_tag;

    logic            r_s2_valid;
    t_tag            r_s2_tag;

    t_sample         r_win [3][3];

    logic            is_max;
    logic            above_thr;
    logic [SAMPLE_W-1:0] center_int;

    // Read port: data is registered and arrives in the cycle after the transaction
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd <= r_line[i_addr];
        end
    end

    // Write back the shifted column; same column recurs no sooner than 3 items later
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line[r_s1_addr] <= {r_rd[SAMPLE_W-1:0], r_s1_sample};
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_addr   <= i_addr;
            r_s1_sample <= i_sample;
            r_s1_tag    <= i_tag;
        end
        if (r_s1_valid) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Window shift: new column enters on the right
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= t_sample'(r_rd[2*SAMPLE_W-1:SAMPLE_W]);
            r_win[1][2] <= t_sample'(r_rd[SAMPLE_W-1:0]);
            r_win[2][2] <= r_s1_sample;
        end
    end

    // Strict local maximum over the eight neighbours
    always_comb begin
        is_max = 1'b1;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!(r == 1 && c == 1) && !(r_win[1][1] > r_win[r][c])) begin
                    is_max = 1'b0;
                end
            end
        end
    end

    // Integer part against threshold; centre must be positive
    assign center_int = $unsigned(r_win[1][1]) >> FRAC_BITS;
    assign above_thr  = (r_win[1][1] > 0)
                     && (center_int > SAMPLE_W'(i_threshold));

    assign o_res_valid           = r_s2_valid && r_s2_tag.emit;
    assign o_res.is_corner       = is_max && above_thr;
    assign o_res.center_column   = r_s2_tag.center_column;
    assign o_res.center_row      = r_s2_tag.center_row;
    assign o_res.frame_end       = r_s2_tag.frame_end;

    assign o_stat.s1_emit = r_s1_valid && r_s1_tag.emit;
    assign o_stat.s2_emit = r_s2_valid && r_s2_tag.emit;

endmodule

`default_nettype wire

// ----- rtl/nonmax_suppress_threshold_3x3_core.sv -----
// Top level: 3x3 non-maximum suppression with threshold on a response stream.
//
// Usage:
//  - Input channel (i_valid/o_ready, i_response): signed Q24.8 corner response
//    samples in raster order, one transaction per pixel.
//  - Output channel (o_valid/i_ready): one result per interior pixel, giving
//    is_corner, the centre column/row and frame_end on the last centre.
//    Border pixels produce no result.
//  - Config channel (i_cfg_valid/o_cfg_ready): index 0 frame width, 1 frame
//    height, 2 corner threshold. Always ready; write only while idle.
//  - Throughput: one sample per cycle while o_ready is high. Set by the single line memory, read
//    in the accept cycle and written back the cycle after.
//  - Pipeline: the sample that completes a window passes through the memory
//    read, the window shift and the compare into the result queue.
//  - Stall: a 4-entry result queue absorbs backpressure; o_ready drops when
//    the queue plus results in flight would overflow it.
//  - Reset: counters, pipeline and queue clear, registers return to
//    640 x 480 and threshold 15000. Line memory is not cleared.
`default_nettype none

module nonmax_suppress_threshold_3x3_core #(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // sample input
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  nmsth_pkg::t_sample         i_response,
    // result output
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic                             o_is_corner,
    output logic [nmsth_pkg::COL_W-1:0]      o_center_column,
    output logic [nmsth_pkg::ROW_W-1:0]      o_center_row,
    output logic                             o_frame_end,
    // configuration
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [nmsth_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [nmsth_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nmsth_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int DW   = 14;
    localparam logic [DW-1:0] MAXW = DW'(MAX_WIDTH);
    localparam int QD   = 4;
    localparam int QPW  = $clog2(QD);
    localparam int QCW  = QPW + 1;

    // Configuration registers
    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [THR_W-1:0] r_threshold;

    // Raster counters
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [DW-1:0]    eff_w;
    logic [FH_W-1:0]  eff_h;
    logic             line_end;
    logic             frame_last;
    logic             in_fire;
    t_tag             tag;

    logic             res_valid;
    t_result          res;
    t_pipe_stat       stat;

    // Result queue
    t_result          r_q [QD];
    logic [QPW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_cnt;
    logic             out_fire;
    logic [QCW-1:0]   used;

    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_threshold    <= THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                REG_THRESHOLD:    r_threshold    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size, clamped
    always_comb begin
        eff_w = DW'(r_frame_width);
        if (eff_w < DW'(MIN_DIM)) begin
            eff_w = DW'(MIN_DIM);
        end else if (eff_w > MAXW) begin
            eff_w = MAXW;
        end
        eff_h = r_frame_height;
        if (eff_h < FH_W'(MIN_DIM)) begin
            eff_h = FH_W'(MIN_DIM);
        end else if (eff_h > MAX_HEIGHT) begin
            eff_h = MAX_HEIGHT;
        end
    end

    assign line_end   = DW'(r_col) >= (eff_w - DW'(1));
    assign frame_last = line_end && (FH_W'(r_row) >= (eff_h - FH_W'(1)));
    assign in_fire    = i_valid && o_ready;

    // Centre tag for the window this sample completes
    assign tag.emit          = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign tag.center_column = r_col - COL_W'(1);
    assign tag.center_row    = r_row - ROW_W'(1);
    assign tag.frame_end     = frame_last;

    // Counter advance
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (line_end) begin
            n_col = '0;
            n_row = frame_last ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    nmsth_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_fire),
        .i_addr      (AW'(r_col)),
        .i_sample    (i_response),
        .i_tag       (tag),
        .i_threshold (r_threshold),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_stat      (stat)
    );

    // Credit: queue entries plus results still in the pipeline
    assign used    = r_cnt + QCW'(stat.s1_emit) + QCW'(stat.s2_emit);
    assign o_ready = used < QCW'(QD);

    assign out_fire = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_q[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (res_valid) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (out_fire) begin
                r_rp <= r_rp + QPW'(1);
            end
            r_cnt <= r_cnt + QCW'(res_valid) - QCW'(out_fire);
        end
    end

    // Output from queue head
    assign o_valid         = r_cnt != '0;
    assign o_is_corner     = r_q[r_rp].is_corner;
    assign o_center_column = r_q[r_rp].center_column;
    assign o_center_row    = r_q[r_rp].center_row;
    assign o_frame_end     = r_q[r_rp].frame_end;

endmodule

`default_nettype wire
